/* hw/rtl/pcvs_pkg.sv */
// ----------------------------------------------------------------------------
// pcvs_pkg: shared definitions for the pulse-count voice sequencer
// Widths, operation and mode codes, sequence timing constants and the
// control and status bundles passed between the sequencer and its queue.
// ----------------------------------------------------------------------------
package pcvs_pkg;

   localparam int QUEUE_DEPTH = 20;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int OP_W       = 2;
   localparam int SECTION_W  = 8;
   localparam int MODE_W     = 2;
   localparam int QUEUED_W   = 5;
   localparam int TICK_W     = 10;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_PLAY = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP = 2'd2;

   // Sequencer modes, also reported on the response.
   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PLAY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WAIT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_STOP = 2'd3;

   // Play sequence timing, in ticks.
   localparam logic [TICK_W-1:0] PLAY_RST_LOW_TICK  = 10'd2;
   localparam logic [TICK_W-1:0] PLAY_DATA_TICK     = 10'd4;
   localparam logic [TICK_W-1:0] PLAY_OVERHEAD      = 10'd6;

   // Stop sequence timing, in ticks.
   localparam logic [TICK_W-1:0] STOP_RST_HIGH_TICK = 10'd1;
   localparam logic [TICK_W-1:0] STOP_RST_LOW_TICK  = 10'd3;
   localparam logic [TICK_W-1:0] STOP_LEN           = 10'd4;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } queue_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]     count;
      logic [SECTION_W-1:0] head;
   } queue_stat_type;

endpackage

/* hw/rtl/pulse_count_voice_sequencer.sv */
// ----------------------------------------------------------------------------
// pulse_count_voice_sequencer: reset/data line sequencer for a voice chip
// Runs the play and stop pulse sequences for a pulse-count voice chip,
// queues play requests that cannot start at once, and reports the line
// levels and sequencer status after every request.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_ready  op, section, busy_in
//   rsp_     out        rsp_valid/rsp_ready  rst_out, data_out, mode,
//                                            current_section, queued,
//                                            end_event, dropped
//
// One request is accepted per cycle while req_ready is high, and every
// request yields exactly one registered response. The sequencer state is
// updated in the cycle of acceptance, so back-to-back requests see the
// effect of their predecessors without a bubble. A two-entry output stage
// (output register plus skid register) keeps req_ready high while one
// response waits; req_ready drops only when both entries are full.
// Synchronous active-high reset clears the mode, counters, line levels and
// the queue fill count; queue entries are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module pulse_count_voice_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pcvs_pkg::OP_W-1:0]      req_op,
   input  logic [pcvs_pkg::SECTION_W-1:0] req_section,
   input  logic                           req_busy_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_rst_out,
   output logic                           rsp_data_out,
   output logic [pcvs_pkg::MODE_W-1:0]    rsp_mode,
   output logic [pcvs_pkg::SECTION_W-1:0] rsp_current_section,
   output logic [pcvs_pkg::QUEUED_W-1:0]  rsp_queued,
   output logic                           rsp_end_event,
   output logic                           rsp_dropped
);
   import pcvs_pkg::*;

   typedef struct packed {
      logic                 rst_out;
      logic                 data_out;
      logic [MODE_W-1:0]    mode;
      logic [SECTION_W-1:0] current_section;
      logic [QUEUED_W-1:0]  queued;
      logic                 end_event;
      logic                 dropped;
   } rsp_type;

   // Sequencer state.
   logic [MODE_W-1:0]    mode_ff,      mode_in;
   logic [TICK_W-1:0]    tick_ff,      tick_in;
   logic [SECTION_W-1:0] section_ff,   section_in;
   logic                 rst_line_ff,  rst_line_in;
   logic                 data_line_ff, data_line_in;

   // Output stage.
   rsp_type              rsp_ff,       rsp_in;
   rsp_type              skid_ff,      skid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 skid_valid_ff, skid_valid_in;

   logic                 accept;
   logic                 take;
   logic                 end_ev;
   logic                 drop;
   logic                 idle_busy;
   logic [TICK_W-1:0]    tick_inc;
   logic [TICK_W-1:0]    play_limit;
   logic [CNT_W-1:0]     count_after;
   logic [QUEUED_W+CNT_W-1:0] count_wide;
   queue_cmd_type        q_cmd;
   queue_stat_type       q_stat;
   rsp_type              result;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign take      = rsp_valid_ff && rsp_ready;
   assign idle_busy = (mode_ff == MODE_IDLE) && req_busy_in;
   assign tick_inc  = tick_ff + TICK_W'(1);

   // A play sequence lasts 2*(section+1)+4 ticks.
   assign play_limit = TICK_W'({section_ff, 1'b0}) + PLAY_OVERHEAD;

   pcvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_cmd),
      .push_data (req_section),
      .stat      (q_stat)
   );

   // Next sequencer state for the request being accepted.
   always_comb begin
      mode_in      = mode_ff;
      tick_in      = tick_ff;
      section_in   = section_ff;
      rst_line_in  = rst_line_ff;
      data_line_in = data_line_ff;
      q_cmd        = '0;
      end_ev       = 1'b0;
      drop         = 1'b0;
      count_after  = q_stat.count;

      if (accept) begin
         unique case (req_op)
            OP_TICK: begin
               unique case (mode_ff)
                  MODE_PLAY: begin
                     // Reset pulse first, then data toggles once per tick.
                     priority if (tick_ff == '0) begin
                        rst_line_in  = 1'b1;
                        data_line_in = 1'b0;
                     end else if (tick_ff == PLAY_RST_LOW_TICK) begin
                        rst_line_in = 1'b0;
                     end else if (tick_ff >= PLAY_DATA_TICK) begin
                        data_line_in = !data_line_ff;
                     end else begin
                        data_line_in = data_line_ff;
                     end
                     tick_in = tick_inc;
                     if (tick_inc >= play_limit) begin
                        tick_in      = '0;
                        rst_line_in  = 1'b0;
                        data_line_in = 1'b0;
                        mode_in      = MODE_WAIT;
                     end
                  end
                  MODE_STOP: begin
                     priority if (tick_ff == '0) begin
                        data_line_in = 1'b0;
                     end else if (tick_ff == STOP_RST_HIGH_TICK) begin
                        rst_line_in = 1'b1;
                     end else if (tick_ff == STOP_RST_LOW_TICK) begin
                        rst_line_in = 1'b0;
                     end else begin
                        rst_line_in = rst_line_ff;
                     end
                     tick_in = tick_inc;
                     if (tick_inc >= STOP_LEN) begin
                        tick_in      = '0;
                        rst_line_in  = 1'b0;
                        data_line_in = 1'b0;
                        mode_in      = MODE_WAIT;
                     end
                  end
                  MODE_WAIT: begin
                     // Once the chip reports idle, start the next queued
                     // section or finish playback.
                     if (req_busy_in) begin
                        if (q_stat.count == '0) begin
                           section_in = '0;
                           mode_in    = MODE_IDLE;
                           end_ev     = 1'b1;
                        end else begin
                           section_in  = q_stat.head;
                           q_cmd.pop   = 1'b1;
                           count_after = q_stat.count - CNT_W'(1);
                           mode_in     = MODE_PLAY;
                           tick_in     = '0;
                        end
                     end
                  end
                  default: begin
                     mode_in = mode_ff;
                  end
               endcase
            end
            OP_PLAY: begin
               priority if (idle_busy) begin
                  mode_in    = MODE_PLAY;
                  section_in = req_section;
                  tick_in    = '0;
               end else if ((req_section != '0) &&
                            (q_stat.count < CNT_W'(QUEUE_DEPTH))) begin
                  q_cmd.push  = 1'b1;
                  count_after = q_stat.count + CNT_W'(1);
               end else begin
                  drop = 1'b1;
               end
            end
            OP_STOP: begin
               if (!idle_busy) begin
                  q_cmd.clear = 1'b1;
                  count_after = '0;
                  // A stop that lands early in a sequence resumes from the
                  // current count.
                  if (tick_ff >= STOP_LEN) begin
                     tick_in = '0;
                  end
                  section_in = '0;
                  mode_in    = MODE_STOP;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   assign count_wide = {QUEUED_W'(0), count_after};

   always_comb begin
      result.rst_out         = rst_line_in;
      result.data_out        = data_line_in;
      result.mode            = mode_in;
      result.current_section = section_in;
      result.queued          = count_wide[QUEUED_W-1:0];
      result.end_event       = end_ev;
      result.dropped         = drop;
   end

   // Output register with a skid entry behind it.
   always_comb begin
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (skid_valid_ff && take) begin
         rsp_in        = skid_ff;
         skid_valid_in = 1'b0;
      end else if (!rsp_valid_ff || take) begin
         rsp_in       = result;
         rsp_valid_in = accept;
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end else begin
         skid_valid_in = skid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         tick_ff       <= '0;
         section_ff    <= '0;
         rst_line_ff   <= 1'b0;
         data_line_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         tick_ff       <= tick_in;
         section_ff    <= section_in;
         rst_line_ff   <= rst_line_in;
         data_line_ff  <= data_line_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rst_out         = rsp_ff.rst_out;
   assign rsp_data_out        = rsp_ff.data_out;
   assign rsp_mode            = rsp_ff.mode;
   assign rsp_current_section = rsp_ff.current_section;
   assign rsp_queued          = rsp_ff.queued;
   assign rsp_end_event       = rsp_ff.end_event;
   assign rsp_dropped         = rsp_ff.dropped;

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count exceeds depth");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while output register empty");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (section_ff == '0 && !rst_line_ff && !data_line_ff))
      else $error("idle mode with active section or driven lines");

   a_play_bound: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_PLAY) |-> (tick_ff < play_limit))
      else $error("play tick count past sequence length");
`endif

endmodule

/* hw/rtl/pcvs_cell.sv */
// ----------------------------------------------------------------------------
// pcvs_cell: one entry of the section queue
// Holds one section. It is loaded from the push data when it is the tail
// slot, and takes its neighbor's section when the queue advances.
// ----------------------------------------------------------------------------
module pcvs_cell (
   input  logic                           clock,
   input  logic                           load_en,
   input  logic                           shift_en,
   input  logic [pcvs_pkg::SECTION_W-1:0] load_data,
   input  logic [pcvs_pkg::SECTION_W-1:0] neighbor_data,
   output logic [pcvs_pkg::SECTION_W-1:0] cell_data
);
   import pcvs_pkg::*;

   logic [SECTION_W-1:0] value_ff;
   logic [SECTION_W-1:0] value_in;

   always_comb begin
      priority if (load_en) begin
         value_in = load_data;
      end else if (shift_en) begin
         value_in = neighbor_data;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_data = value_ff;

endmodule

/* hw/rtl/pcvs_queue.sv */
// ----------------------------------------------------------------------------
// pcvs_queue: section queue built as a chain of cells
// The head sits in cell zero. A pop moves every cell one step toward the
// head; a push loads the cell just past the last filled one.
// ----------------------------------------------------------------------------
module pcvs_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  pcvs_pkg::queue_cmd_type        cmd,
   input  logic [pcvs_pkg::SECTION_W-1:0] push_data,
   output pcvs_pkg::queue_stat_type       stat
);
   import pcvs_pkg::*;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [SECTION_W-1:0] cell_value [QUEUE_DEPTH];

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         logic [SECTION_W-1:0] neighbor;
         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign neighbor = '0;
         end else begin : g_mid
            assign neighbor = cell_value[i+1];
         end
         pcvs_cell u_cell (
            .clock         (clock),
            .load_en       (cmd.push && (count_ff == CNT_W'(i))),
            .shift_en      (cmd.pop),
            .load_data     (push_data),
            .neighbor_data (neighbor),
            .cell_data     (cell_value[i])
         );
      end
   endgenerate

   always_comb begin
      priority if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.count = count_ff;
   assign stat.head  = cell_value[0];

endmodule
